FILE: src/jsu_pkg.sv
// shared types and constants for the json string unescaper
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // error codes carried on the result channel
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_ESC   = 2'd1;
    localparam logic [1:0] ERR_BAD_HEX   = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED = 2'd3;

    // default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // one decoded job: up to three output bytes caused by one input byte
    typedef struct packed {
        logic [1:0]      count;    // number of bytes, 1..3
        logic [2:0][7:0] bytes;    // bytes[0] goes out first
        logic            str_end;  // last job of the string
        logic [1:0]      err;      // error code, bytes are zero on error
    } job_t;

endpackage

`default_nettype wire

FILE: src/jsu_front.sv
// front end: escape decoding state machine that turns input bytes into jobs
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_accept,
    input  wire logic [7:0]   in_byte,
    input  wire logic         in_last,
    output jsu_pkg::job_t     push_job,
    output logic              push
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        ST_NORMAL = 3'd0,
        ST_ESC    = 3'd1,
        ST_HEX1   = 3'd2,
        ST_HEX2   = 3'd3,
        ST_HEX3   = 3'd4,
        ST_HEX4   = 3'd5
    } mode_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;

    mode_t       mode_reg, mode_next;
    logic [11:0] acc_reg, acc_next;
    logic        drop_reg, drop_next;

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] cp;

    function automatic job_t mk_one(input logic [7:0] b, input logic last);
        job_t j;
        j          = '0;
        j.count    = 2'd1;
        j.bytes[0] = b;
        j.str_end  = last;
        j.err      = ERR_NONE;
        return j;
    endfunction

    function automatic job_t mk_fail(input logic [1:0] code);
        job_t j;
        j         = '0;
        j.count   = 2'd1;
        j.str_end = 1'b1;
        j.err     = code;
        return j;
    endfunction

    // hex digit decode, either case
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            hex_val = 4'(in_byte - 8'h30);
        end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
            hex_val = 4'(in_byte - 8'h57);
        end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
            hex_val = 4'(in_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign cp = {acc_reg, hex_val};

    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        drop_next = drop_reg;
        push_job  = '0;
        push      = 1'b0;
        if (in_accept) begin
            if (drop_reg) begin
                if (in_last) begin
                    drop_next = 1'b0;
                end
            end else begin
                unique case (mode_reg)
                    ST_ESC: begin
                        mode_next = ST_NORMAL;
                        push      = 1'b1;
                        unique case (in_byte)
                            CH_T:      push_job = mk_one(8'h09, in_last);
                            CH_R:      push_job = mk_one(8'h0D, in_last);
                            CH_N:      push_job = mk_one(8'h0A, in_last);
                            CH_B:      push_job = mk_one(8'h08, in_last);
                            CH_F:      push_job = mk_one(8'h0C, in_last);
                            CH_ZERO:   push_job = mk_one(8'h00, in_last);
                            CH_BSLASH: push_job = mk_one(CH_BSLASH, in_last);
                            CH_SLASH:  push_job = mk_one(CH_SLASH, in_last);
                            CH_QUOTE:  push_job = mk_one(CH_QUOTE, in_last);
                            CH_U: begin
                                if (in_last) begin
                                    push_job  = mk_fail(ERR_TRUNCATED);
                                end else begin
                                    push      = 1'b0;
                                    mode_next = ST_HEX1;
                                    acc_next  = '0;
                                end
                            end
                            default: begin
                                push_job  = mk_fail(ERR_BAD_ESC);
                                drop_next = !in_last;
                            end
                        endcase
                        if (push_job.err == ERR_TRUNCATED) begin
                            acc_next = '0;
                        end
                    end
                    ST_HEX1, ST_HEX2, ST_HEX3, ST_HEX4: begin
                        if (!hex_ok) begin
                            push      = 1'b1;
                            push_job  = mk_fail(ERR_BAD_HEX);
                            mode_next = ST_NORMAL;
                            acc_next  = '0;
                            drop_next = !in_last;
                        end else if (mode_reg != ST_HEX4) begin
                            if (in_last) begin
                                push      = 1'b1;
                                push_job  = mk_fail(ERR_TRUNCATED);
                                mode_next = ST_NORMAL;
                                acc_next  = '0;
                            end else begin
                                acc_next  = {acc_reg[7:0], hex_val};
                                mode_next = mode_t'(mode_reg + 3'd1);
                            end
                        end else begin
                            // fourth digit: encode the code point as utf-8
                            push      = 1'b1;
                            mode_next = ST_NORMAL;
                            acc_next  = '0;
                            push_job.str_end = in_last;
                            push_job.err     = ERR_NONE;
                            if (cp < 16'h0080) begin
                                push_job.count    = 2'd1;
                                push_job.bytes[0] = cp[7:0];
                            end else if (cp < 16'h0800) begin
                                push_job.count    = 2'd2;
                                push_job.bytes[0] = {3'b110, cp[10:6]};
                                push_job.bytes[1] = {2'b10, cp[5:0]};
                            end else begin
                                push_job.count    = 2'd3;
                                push_job.bytes[0] = {4'b1110, cp[15:12]};
                                push_job.bytes[1] = {2'b10, cp[11:6]};
                                push_job.bytes[2] = {2'b10, cp[5:0]};
                            end
                        end
                    end
                    default: begin
                        mode_next = ST_NORMAL;
                        if (in_byte == CH_BSLASH) begin
                            if (in_last) begin
                                push     = 1'b1;
                                push_job = mk_fail(ERR_TRUNCATED);
                                acc_next = '0;
                            end else begin
                                mode_next = ST_ESC;
                            end
                        end else begin
                            push     = 1'b1;
                            push_job = mk_one(in_byte, in_last);
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ST_NORMAL;
            acc_reg  <= '0;
            drop_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            drop_reg <= drop_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/jsu_queue.sv
// small job queue between the decoding front and the output back
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire jsu_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output jsu_pkg::job_t      head,
    output logic               not_empty
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t              slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slots[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/jsu_back.sv
// back end: splits each job into output bytes behind an output register
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire jsu_pkg::job_t head,
    input  wire logic          head_valid,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               out_run_last,
    output logic               out_str_end,
    output logic [1:0]         out_err
);
    import jsu_pkg::*;

    logic       valid_reg;
    logic [1:0] idx_reg;
    logic [7:0] byte_reg;
    logic       run_last_reg, str_end_reg;
    logic [1:0] err_reg;
    logic       load, at_end;

    assign load   = head_valid && (!valid_reg || out_ready);
    assign at_end = (2'(idx_reg + 2'd1) == head.count);
    assign pop    = load && at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= at_end ? 2'd0 : 2'(idx_reg + 2'd1);
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg     <= head.bytes[idx_reg];
            run_last_reg <= at_end;
            str_end_reg  <= at_end && head.str_end;
            err_reg      <= head.err;
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign out_run_last = run_last_reg;
    assign out_str_end  = str_end_reg;
    assign out_err      = err_reg;

endmodule

`default_nettype wire

FILE: src/json_string_unescaper.sv
// top level of the json string unescaper: front decoder, job queue, output back end
//
//  channel | dir | tdata           | tlast       | tuser (low bit up)
//  s_      | in  | in_byte [7:0]   | in_last     | -
//  m_      | out | out_byte [7:0]  | string_end  | run_last, error_code[1:0]
//
// one input byte is taken per cycle while the job queue has room; a byte
// yields zero to three output bytes, and the back end sends one output byte
// per cycle while m_tready is high, so a \u escape that makes three bytes
// goes out as three transfers (it has taken six input bytes to build it)
// reset is synchronous on aresetn low and clears the escape state and queue
// the queue decouples the sides: a stall on m_tready only stops input once
// the queue of QUEUE_DEPTH jobs is full (user must set at least 2; unchecked)
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescaper #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tlast,   // in_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tlast,   // string_end
    output logic [2:0]      m_tuser    // [0] run_last, [2:1] error_code
);
    import jsu_pkg::*;

    job_t push_job, head;
    logic push, full, pop, head_valid;
    logic in_accept;
    logic run_last;
    logic [1:0] err;

    // input transfer happens when s_tvalid is high and there is room in the queue
    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    jsu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .push_job  (push_job),
        .push      (push)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .not_empty (head_valid)
    );

    jsu_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (m_tdata),
        .out_run_last (run_last),
        .out_str_end  (m_tlast),
        .out_err      (err)
    );

    assign m_tuser = {err, run_last};

    // an error transfer is the final result of its string and carries a zero byte
    a_err_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && err != ERR_NONE |-> m_tlast && run_last && m_tdata == 8'h00)
        else $error("error result not marked as end of string");

    // the end of a string is always the end of a byte's results
    a_end_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> run_last)
        else $error("string end without run end");

    // a job is pushed only while the queue has room
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> s_tready)
        else $error("job pushed into a full queue");

    // a multibyte job continues without an error code or string end on its lead bytes
    a_lead_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !run_last |-> err == ERR_NONE && !m_tlast)
        else $error("lead byte of a sequence carries end or error");

endmodule

`default_nettype wire
